// File: src/rtp_pkg.sv
// Shared types, constants and the character classifier for the radix integer text parser.
package rtp_pkg;

    localparam int ACC_WIDTH_DEF = 64;
    localparam int RADIX_W       = 6;
    localparam int MAG_W         = 63;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_X  = 8'h78;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;

    localparam logic [7:0] RADIX_MAX = 8'd36;
    localparam logic [7:0] RADIX_MIN = 8'd2;
    localparam logic [7:0] RADIX_SEL_DEFAULT = 8'd0;
    localparam logic [7:0] RADIX_SEL_HEX = 8'd16;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd63;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_START  = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [RADIX_W-1:0] digit;
        logic               is_space;
        logic               is_minus;
        logic               is_plus;
        logic               is_zero;
        logic               is_x;
        logic               last;
    } t_cls;

    function automatic logic [RADIX_W-1:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd63;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                d = c - CHAR_ZERO;
            end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
                d = c - CHAR_LO_A + 8'd10;
            end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
                d = c - CHAR_UP_A + 8'd10;
            end
            return d[RADIX_W-1:0];
        end
    endfunction

endpackage

// File: src/rtp_in_if.sv
// Input channel carrying one text byte per word.
interface rtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_byte;

    modport source (output valid, output char_byte, output last_byte, input ready);
    modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

// File: src/rtp_out_if.sv
// Output channel carrying one parse result per word.
interface rtp_out_if;
    logic        valid;
    logic        ready;
    logic        is_number;
    logic        negative;
    logic [62:0] magnitude;

    modport source (output valid, output is_number, output negative, output magnitude,
                    input ready);
    modport sink   (input valid, input is_number, input negative, input magnitude,
                    output ready);
endinterface

// File: src/rtp_front.sv
// Front end: accepts text bytes and classifies each one for the queue.
module rtp_front
    import rtp_pkg::*;
(
    rtp_in_if.sink i_byte,
    input  logic   i_push_ready,
    output logic   o_push,
    output t_cls   o_push_data
);

    assign i_byte.ready = i_push_ready;
    assign o_push       = i_byte.valid & i_push_ready;

    always_comb begin
        o_push_data.digit    = digit_value(i_byte.char_byte);
        o_push_data.is_space = (i_byte.char_byte == CHAR_SPACE);
        o_push_data.is_minus = (i_byte.char_byte == CHAR_MINUS);
        o_push_data.is_plus  = (i_byte.char_byte == CHAR_PLUS);
        o_push_data.is_zero  = (i_byte.char_byte == CHAR_ZERO);
        o_push_data.is_x     = (i_byte.char_byte == CHAR_LO_X) ||
                               (i_byte.char_byte == CHAR_UP_X);
        o_push_data.last     = i_byte.last_byte;
    end

endmodule

// File: src/rtp_queue.sv
// Two-entry queue of classified bytes between the front and back ends.
module rtp_queue
    import rtp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_push_data,
    output logic o_push_ready,
    input  logic i_pop,
    output logic o_pop_valid,
    output t_cls o_pop_data
);

    t_cls       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: src/rtp_back.sv
// Back end: runs the parse state machine and the digit multiply-add, and holds the result.
module rtp_back
    import rtp_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_radix_setting,
    input  logic       i_valid,
    input  t_cls       i_item,
    output logic       o_pop,
    rtp_out_if.source  o_result
);

    t_phase                r_phase, n_phase;
    logic                  r_minus, n_minus;
    logic [ACC_WIDTH-1:0]  r_acc, n_acc;
    logic                  r_digit_seen, n_digit_seen;
    logic [RADIX_W-1:0]    r_wr, n_wr;
    logic                  r_pending, n_pending;
    logic                  r_prefix_ok, n_prefix_ok;

    logic                  r_out_valid;
    logic                  r_out_num;
    logic                  r_out_neg;
    logic [MAG_W-1:0]      r_out_mag;

    logic                  set_bad;
    logic [RADIX_W-1:0]    set_radix;
    logic                  set_pok;
    logic [RADIX_W-1:0]    radix_used;
    logic                  pok_used;
    logic                  do_first;
    logic                  do_take;
    logic [ACC_WIDTH+RADIX_W-1:0] prod;
    logic                  slot_free;
    logic                  fin_num;
    logic [MAG_W-1:0]      fin_mag;

    always_comb begin
        set_bad   = 1'b0;
        set_radix = i_radix_setting[RADIX_W-1:0];
        set_pok   = (i_radix_setting == RADIX_SEL_HEX);
        if (i_radix_setting == RADIX_SEL_DEFAULT) begin
            set_radix = RADIX_DEC;
            set_pok   = 1'b1;
        end else if (i_radix_setting < RADIX_MIN || i_radix_setting > RADIX_MAX) begin
            set_bad = 1'b1;
        end
    end

    assign prod = ({{RADIX_W{1'b0}}, r_acc} * {{ACC_WIDTH{1'b0}}, radix_used})
                + {{ACC_WIDTH{1'b0}}, i_item.digit};

    always_comb begin
        n_phase      = r_phase;
        n_minus      = r_minus;
        n_acc        = r_acc;
        n_digit_seen = r_digit_seen;
        n_wr         = r_wr;
        n_pending    = r_pending;
        n_prefix_ok  = r_prefix_ok;
        radix_used   = r_wr;
        pok_used     = r_prefix_ok;
        do_first     = 1'b0;
        do_take      = 1'b0;

        unique case (r_phase)
            PH_SKIP: begin
                if (!i_item.is_space) begin
                    if (set_bad) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_wr        = set_radix;
                        n_prefix_ok = set_pok;
                        radix_used  = set_radix;
                        pok_used    = set_pok;
                        if (i_item.is_minus) begin
                            n_minus = 1'b1;
                            n_phase = PH_START;
                        end else if (i_item.is_plus) begin
                            n_phase = PH_START;
                        end else begin
                            do_first = 1'b1;
                        end
                    end
                end
            end
            PH_START: begin
                do_first = 1'b1;
            end
            PH_DIGITS: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    if (i_item.is_x) begin
                        n_wr = RADIX_HEX;
                    end else begin
                        n_digit_seen = 1'b1;
                        do_take      = 1'b1;
                    end
                end else begin
                    do_take = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (do_first) begin
            n_phase = PH_DIGITS;
            if (pok_used && i_item.is_zero) begin
                n_pending = 1'b1;
            end else begin
                do_take = 1'b1;
            end
        end

        if (do_take) begin
            if (i_item.digit >= radix_used) begin
                n_phase = PH_DONE;
            end else begin
                n_acc        = prod[ACC_WIDTH-1:0];
                n_digit_seen = 1'b1;
            end
        end
    end

    always_comb begin
        fin_num = (n_digit_seen | n_pending) & ~n_acc[ACC_WIDTH-1];
        fin_mag = '0;
        if (fin_num) begin
            fin_mag[ACC_WIDTH-2:0] = n_acc[ACC_WIDTH-2:0];
        end
    end

    assign slot_free = ~r_out_valid | o_result.ready;
    assign o_pop     = i_valid & (~i_item.last | slot_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SKIP;
            r_minus      <= 1'b0;
            r_acc        <= '0;
            r_digit_seen <= 1'b0;
            r_wr         <= RADIX_DEC;
            r_pending    <= 1'b0;
            r_prefix_ok  <= 1'b0;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_phase      <= PH_SKIP;
                r_minus      <= 1'b0;
                r_acc        <= '0;
                r_digit_seen <= 1'b0;
                r_wr         <= RADIX_DEC;
                r_pending    <= 1'b0;
                r_prefix_ok  <= 1'b0;
            end else begin
                r_phase      <= n_phase;
                r_minus      <= n_minus;
                r_acc        <= n_acc;
                r_digit_seen <= n_digit_seen;
                r_wr         <= n_wr;
                r_pending    <= n_pending;
                r_prefix_ok  <= n_prefix_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out_num <= fin_num;
            r_out_neg <= fin_num & n_minus;
            r_out_mag <= fin_mag;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.is_number = r_out_num;
    assign o_result.negative  = r_out_neg;
    assign o_result.magnitude = r_out_mag;

endmodule

// File: src/radix_integer_text_parser.sv
// Top level of the radix integer text parser: radix register, front end, queue and back end.
// Throughput is one text byte per cycle unless the queue is full; a last byte also waits for a held result.
// A result is registered in the back end's result register when its last byte is popped from the queue.
// Input bytes keep flowing while a result waits, until the two-entry queue fills.
// Reset is synchronous and active low; it clears the parse state and sets the radix setting to zero (default).
module radix_integer_text_parser
    import rtp_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    rtp_in_if.sink     i_byte,
    rtp_out_if.source  o_result
);

    logic [7:0] r_radix_setting;
    logic       push;
    logic       push_ready;
    t_cls       push_data;
    logic       pop;
    logic       pop_valid;
    t_cls       pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_setting <= RADIX_SEL_DEFAULT;
        end else if (i_cfg_we) begin
            r_radix_setting <= i_cfg_wdata;
        end
    end

    rtp_front u_front (
        .i_byte       (i_byte),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    rtp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data)
    );

    rtp_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_radix_setting (r_radix_setting),
        .i_valid         (pop_valid),
        .i_item          (pop_data),
        .o_pop           (pop),
        .o_result        (o_result)
    );

endmodule

// File: tb/radix_integer_text_parser_tb.sv
// Self-checking testbench for the radix integer text parser with directed and random text.
module radix_integer_text_parser_tb;
    import rtp_pkg::*;

    localparam int QUIET_LIMIT = 500;

    typedef struct packed {
        logic             is_number;
        logic             negative;
        logic [MAG_W-1:0] magnitude;
    } t_parsed_number;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [7:0] i_cfg_wdata;

    rtp_in_if  byte_if ();
    rtp_out_if result_if ();

    radix_integer_text_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (byte_if),
        .o_result    (result_if)
    );

    // Mirror of the parse state.
    logic [7:0]               radix_mirror;
    t_phase                   scan_phase;
    logic                     minus_taken;
    logic                     digit_taken;
    logic                     zero_held;
    logic                     hex_allowed;
    logic [RADIX_W-1:0]       digit_base;
    logic [ACC_WIDTH_DEF-1:0] running_value;

    t_parsed_number parsed_numbers[$];
    t_parsed_number oldest_number;

    int unsigned mismatch_count = 0;
    int unsigned bytes_sent;
    int unsigned sink_stall_left = 0;
    int unsigned quiet_cycles = 0;
    bit          sender_idles;
    bit          receiver_stalls;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned char_digit(logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return 32'(c - CHAR_ZERO);
        if (c >= CHAR_LO_A && c <= CHAR_LO_Z) return c - CHAR_LO_A + 10;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) return c - CHAR_UP_A + 10;
        return 255;
    endfunction

    function automatic void clear_parse();
        scan_phase    = PH_SKIP;
        minus_taken   = 1'b0;
        digit_taken   = 1'b0;
        zero_held     = 1'b0;
        hex_allowed   = 1'b0;
        digit_base    = RADIX_DEC;
        running_value = '0;
    endfunction

    function automatic void take_char_digit(logic [7:0] c);
        int unsigned d;
        d = char_digit(c);
        if (d >= digit_base) begin
            scan_phase = PH_DONE;
        end else begin
            running_value = running_value * ACC_WIDTH_DEF'(digit_base) + ACC_WIDTH_DEF'(d);
            digit_taken   = 1'b1;
        end
    endfunction

    function automatic void open_number(logic [7:0] c);
        scan_phase = PH_DIGITS;
        if (hex_allowed && c == CHAR_ZERO) begin
            zero_held = 1'b1;
        end else begin
            take_char_digit(c);
        end
    endfunction

    function automatic void parse_char(logic [7:0] c, logic last);
        t_parsed_number number;
        logic           valid_number;
        case (scan_phase)
            PH_SKIP: begin
                if (c != CHAR_SPACE) begin
                    if (radix_mirror == RADIX_SEL_DEFAULT) begin
                        digit_base  = RADIX_DEC;
                        hex_allowed = 1'b1;
                    end else if (radix_mirror < RADIX_MIN || radix_mirror > RADIX_MAX) begin
                        scan_phase = PH_DONE;
                    end else begin
                        digit_base  = radix_mirror[RADIX_W-1:0];
                        hex_allowed = (radix_mirror == RADIX_SEL_HEX);
                    end
                    if (scan_phase != PH_DONE) begin
                        if (c == CHAR_MINUS) begin
                            minus_taken = 1'b1;
                            scan_phase  = PH_START;
                        end else if (c == CHAR_PLUS) begin
                            scan_phase = PH_START;
                        end else begin
                            open_number(c);
                        end
                    end
                end
            end
            PH_START: begin
                open_number(c);
            end
            PH_DIGITS: begin
                if (zero_held) begin
                    zero_held = 1'b0;
                    if (c == CHAR_LO_X || c == CHAR_UP_X) begin
                        digit_base = RADIX_HEX;
                    end else begin
                        digit_taken = 1'b1;
                        take_char_digit(c);
                    end
                end else begin
                    take_char_digit(c);
                end
            end
            default: begin
            end
        endcase
        if (last) begin
            if (zero_held) digit_taken = 1'b1;
            valid_number     = digit_taken && !running_value[ACC_WIDTH_DEF-1];
            number.is_number = valid_number;
            number.negative  = valid_number && minus_taken;
            number.magnitude = valid_number ? running_value[MAG_W-1:0] : '0;
            parsed_numbers.push_back(number);
            clear_parse();
        end
    endfunction

    function automatic void flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch in %s at %0t: expected %h, got %h", field, $realtime, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (parsed_numbers.size() == 0) begin
                flag_mismatch("unexpected result", '0, 64'(result_if.magnitude));
            end else begin
                oldest_number = parsed_numbers.pop_front();
                if (result_if.is_number !== oldest_number.is_number) begin
                    flag_mismatch("is_number", 64'(oldest_number.is_number),
                                  64'(result_if.is_number));
                end
                if (result_if.negative !== oldest_number.negative) begin
                    flag_mismatch("negative", 64'(oldest_number.negative),
                                  64'(result_if.negative));
                end
                if (result_if.magnitude !== oldest_number.magnitude) begin
                    flag_mismatch("magnitude", 64'(oldest_number.magnitude),
                                  64'(result_if.magnitude));
                end
            end
        end
        if (sink_stall_left != 0) begin
            sink_stall_left--;
        end else if (receiver_stalls && $urandom_range(0, 11) == 0) begin
            sink_stall_left = $urandom_range(1, 19);
        end
        result_if.ready <= (sink_stall_left == 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_if.valid && byte_if.ready) ||
            (result_if.valid && result_if.ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles < QUIET_LIMIT) begin
            quiet_cycles++;
        end else begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] c, logic last);
        int unsigned gap;
        if (sender_idles && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.char_byte <= c;
        byte_if.last_byte <= last;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        bytes_sent++;
        parse_char(c, last);
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    task automatic wait_for_results();
        byte_if.valid <= 1'b0;
        while (parsed_numbers.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_radix(logic [7:0] value);
        wait_for_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        radix_mirror = value;
    endtask

    // Mostly well-formed numbers with random content, some noise words and trailing junk.
    task automatic send_random_text();
        logic [7:0]  text[$];
        int unsigned gen_base;
        int unsigned count;
        int unsigned d;
        if ($urandom_range(0, 7) == 0) begin
            count = $urandom_range(1, 6);
            repeat (count) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            if (radix_mirror == RADIX_SEL_DEFAULT) begin
                gen_base = 10;
            end else if (radix_mirror < RADIX_MIN || radix_mirror > RADIX_MAX) begin
                gen_base = 36;
            end else begin
                gen_base = 32'(radix_mirror);
            end
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (count) text.push_back(CHAR_SPACE);
            case ($urandom_range(0, 3))
                0: text.push_back(CHAR_MINUS);
                1: text.push_back(CHAR_PLUS);
                default: begin
                end
            endcase
            if ($urandom_range(0, 3) == 0) begin
                text.push_back(CHAR_ZERO);
                text.push_back($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X);
                if (radix_mirror == RADIX_SEL_DEFAULT || radix_mirror == RADIX_SEL_HEX) begin
                    gen_base = 16;
                end
            end
            count = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 22) : $urandom_range(0, 6);
            repeat (count) begin
                d = $urandom_range(0, gen_base - 1);
                if (d < 10) begin
                    text.push_back(8'(CHAR_ZERO + d));
                end else begin
                    text.push_back(8'(($urandom_range(0, 1) ? CHAR_LO_A : CHAR_UP_A) + d - 10));
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
            end
            if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
        end
        foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    endtask

    task automatic test_default_radix();
        send_string(" ");
        send_string("-");
        send_string("+");
        send_string("0x");
        send_string("0");
        send_string("-0");
        send_string("07");
        send_string(" +7Z");
        send_string("0X1f");
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_invalid_radix();
        write_radix(8'd1);
        send_string(" 5");
        write_radix(RADIX_MAX + 8'd1);
        send_string("9");
        write_radix(8'hFF);
        send_string("-1");
    endtask

    task automatic test_radix_extremes();
        write_radix(RADIX_MIN);
        send_string("1012");
        write_radix(RADIX_MAX);
        send_string("0xZ");
        write_radix(RADIX_SEL_HEX);
        send_string("-0Xg");
        send_string("-0xfF");
    endtask

    task automatic test_random_strings();
        int unsigned start_count;
        int unsigned phase_start;
        start_count = bytes_sent;
        while (bytes_sent - start_count < 1000) begin
            case ($urandom_range(0, 7))
                0: write_radix(RADIX_SEL_DEFAULT);
                1: write_radix(8'd10);
                2: write_radix(RADIX_SEL_HEX);
                3: write_radix(RADIX_MIN);
                4: write_radix(RADIX_MAX);
                5: write_radix(8'($urandom_range(RADIX_MIN, RADIX_MAX)));
                6: write_radix(8'($urandom_range(0, 255)));
                default: write_radix(8'd8);
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 110) begin
                send_random_text();
                if ($urandom_range(0, 24) == 0) wait_for_results();
            end
        end
    endtask

    task automatic test_full_rate();
        int unsigned start_count;
        write_radix(RADIX_SEL_DEFAULT);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        start_count     = bytes_sent;
        while (bytes_sent - start_count < 200) send_random_text();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        byte_if.valid     <= 1'b0;
        byte_if.char_byte <= '0;
        byte_if.last_byte <= 1'b0;
        bytes_sent      = 0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        radix_mirror    = RADIX_SEL_DEFAULT;
        clear_parse();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_radix();
        test_invalid_radix();
        test_radix_extremes();
        test_random_strings();
        test_full_rate();

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && parsed_numbers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/rtp_pkg.sv
src/rtp_in_if.sv
src/rtp_out_if.sv
src/rtp_front.sv
src/rtp_queue.sv
src/rtp_back.sv
src/radix_integer_text_parser.sv
tb/radix_integer_text_parser_tb.sv
